// ===== hw/rtl/abtt_pkg.sv =====
// Shared types and constants for the array binary tree traversal block.
// Holds the store geometry, operation and status codes, word structs and the FSM type.
// Depends on nothing else.
`default_nettype none

package abtt_pkg;

	// Store geometry; every width below but VALUE_W follows from the slot count.
	localparam int TREE_SLOTS   = 32;
	localparam int ADDR_W       = $clog2(TREE_SLOTS);
	localparam int IDX_W        = ADDR_W + 1;
	localparam int PTR_W        = $clog2(TREE_SLOTS + 1);
	localparam int STACK_LEVELS = $clog2(TREE_SLOTS);
	localparam int DEPTH_W      = $clog2(STACK_LEVELS + 1);
	localparam int TOP_W        = (STACK_LEVELS > 1) ? $clog2(STACK_LEVELS) : 1;
	localparam int VALUE_W      = 32;

	// Operation codes.
	localparam logic [2:0] OP_APPEND = 3'd0;
	localparam logic [2:0] OP_CLEAR  = 3'd1;
	localparam logic [2:0] OP_PRE    = 3'd2;
	localparam logic [2:0] OP_IN     = 3'd3;
	localparam logic [2:0] OP_POST   = 3'd4;

	// Status codes.
	localparam logic [1:0] ST_APPENDED = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_CLEARED  = 2'd2;
	localparam logic [1:0] ST_VALUE    = 2'd3;

	// Progress of one stack level through its node.
	typedef enum logic [1:0] {
		PH_LEFT,
		PH_RIGHT,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_FETCH,
		S_VISIT,
		S_FLUSH
	} state_t;

	typedef struct packed {
		logic [2:0]                operation;
		logic signed [VALUE_W-1:0] node_value;
	} in_word_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] out_value;
		logic [1:0]                status;
		logic                      last;
	} out_word_t;

	// Request bundle towards the node store.
	typedef struct packed {
		logic               wr_en;
		logic [ADDR_W-1:0]  wr_addr;
		logic [VALUE_W-1:0] wr_data;
		logic               rd_en;
		logic [ADDR_W-1:0]  rd_addr;
	} ram_req_t;

endpackage

`default_nettype wire

// ===== hw/rtl/abtt_node_ram.sv =====
// Node store of the tree: one write port, one read port, registered read data.
// Per-entry valid bits make unwritten entries read as zero after reset.
// Depends on abtt_pkg.
`default_nettype none

module abtt_node_ram (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire abtt_pkg::ram_req_t         req,
	output logic [abtt_pkg::VALUE_W-1:0]    rd_data
);
	import abtt_pkg::*;

	logic [VALUE_W-1:0] mem [TREE_SLOTS];
	logic [TREE_SLOTS-1:0] valid_q;
	logic [VALUE_W-1:0] raw_s1;
	logic               hit_s1;

	// Storage array, written and read synchronously.
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			raw_s1 <= mem[req.rd_addr];
			hit_s1 <= valid_q[req.rd_addr];
		end
	end

	// Valid bits: cleared by reset, set on the first write to an entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.wr_en) begin
			valid_q[req.wr_addr] <= 1'b1;
		end
	end

	// An entry never written reads as an absent node.
	assign rd_data = hit_s1 ? raw_s1 : '0;

endmodule

`default_nettype wire

// ===== hw/rtl/array_binary_tree_traversal.sv =====
// Heap-indexed binary tree store with depth-first walks. An append or a clear gives one
// word; with the output taken every cycle, such operations run back to back. A traversal
// visits nodes through the single read port of the node store: each pushed node is fetched
// and then visited in its left, right and done phases, each child probe that is in range but
// finds zero adds one fetch, and a final flush step releases the last value; the walk waits
// when it must emit while the output is held up. Input is not accepted while a walk is in
// progress. The store reads as zero after reset without any clearing pass.
`default_nettype none

module array_binary_tree_traversal (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire abtt_pkg::in_word_t   in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output abtt_pkg::out_word_t       out_data
);
	import abtt_pkg::*;

	state_t              state_q, state_d;
	logic [PTR_W-1:0]    wp_q, wp_d;
	logic [DEPTH_W-1:0]  depth_q;
	logic [2:0]          order_q, order_d;
	logic [IDX_W-1:0]    child_q, child_d;
	logic [ADDR_W-1:0]   stk_idx_q [STACK_LEVELS];
	phase_t              stk_ph_q  [STACK_LEVELS];
	logic [VALUE_W-1:0]  stk_val_q [STACK_LEVELS];
	logic [VALUE_W-1:0]  pend_q;
	logic                pend_valid_q;
	out_word_t           out_q, out_d;
	logic                out_valid_q;

	ram_req_t            ram_req;
	logic [VALUE_W-1:0]  rd_data;

	logic                accept, is_walk, out_free;
	logic [TOP_W-1:0]    top_ptr;
	logic [ADDR_W-1:0]   t_idx;
	phase_t              t_ph;
	logic [VALUE_W-1:0]  t_val;
	logic [IDX_W-1:0]    t_child;
	logic                child_ok, emit, stall;
	logic                out_load, pend_load, pend_drop;
	logic                push_en, pop_en, phase_en;
	phase_t              phase_nx;

	abtt_node_ram u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (ram_req),
		.rd_data (rd_data)
	);

	// Handshake and top-of-stack view.
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE) && out_free;
	assign accept    = in_valid && in_ready;
	assign is_walk   = (in_data.operation == OP_PRE) || (in_data.operation == OP_IN) ||
			(in_data.operation == OP_POST);
	assign top_ptr   = TOP_W'(depth_q - DEPTH_W'(1));
	assign t_idx     = stk_idx_q[top_ptr];
	assign t_ph      = stk_ph_q[top_ptr];
	assign t_val     = stk_val_q[top_ptr];
	assign t_child   = {t_idx, (t_ph == PH_RIGHT)};
	assign child_ok  = t_child < IDX_W'(TREE_SLOTS);
	assign emit      = ((t_ph == PH_LEFT) && (order_q == OP_PRE)) ||
			((t_ph == PH_RIGHT) && (order_q == OP_IN)) ||
			((t_ph == PH_DONE) && (order_q == OP_POST));
	assign stall     = emit && pend_valid_q && !out_free;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && is_walk) begin
					state_d = S_FETCH;
				end
			end
			S_FETCH: begin
				state_d = S_VISIT;
			end
			S_VISIT: begin
				if (!stall) begin
					case (t_ph)
						PH_LEFT, PH_RIGHT: begin
							if (child_ok) begin
								state_d = S_FETCH;
							end
						end
						PH_DONE: begin
							if (depth_q == DEPTH_W'(1)) begin
								state_d = S_FLUSH;
							end
						end
						default: ;
					endcase
				end
			end
			S_FLUSH: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Datapath controls for each state.
	always_comb begin
		ram_req   = '0;
		wp_d      = wp_q;
		order_d   = order_q;
		child_d   = child_q;
		out_load  = 1'b0;
		out_d     = out_q;
		pend_load = 1'b0;
		pend_drop = 1'b0;
		push_en   = 1'b0;
		pop_en    = 1'b0;
		phase_en  = 1'b0;
		phase_nx  = PH_DONE;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (in_data.operation)
						OP_APPEND: begin
							out_load = 1'b1;
							out_d    = '{out_value: '0, status: ST_FULL, last: 1'b1};
							if (wp_q < PTR_W'(TREE_SLOTS)) begin
								ram_req.wr_en   = 1'b1;
								ram_req.wr_addr = wp_q[ADDR_W-1:0];
								ram_req.wr_data = in_data.node_value;
								wp_d            = wp_q + PTR_W'(1);
								out_d.status    = ST_APPENDED;
							end
						end
						OP_CLEAR: begin
							wp_d     = PTR_W'(1);
							out_load = 1'b1;
							out_d    = '{out_value: '0, status: ST_CLEARED, last: 1'b1};
						end
						OP_PRE, OP_IN, OP_POST: begin
							ram_req.rd_en   = 1'b1;
							ram_req.rd_addr = ADDR_W'(1);
							child_d         = IDX_W'(1);
							order_d         = in_data.operation;
						end
						default: ;
					endcase
				end
			end
			S_FETCH: begin
				// The root is always walked; other children only when present.
				push_en = (child_q == IDX_W'(1)) || (rd_data != '0);
			end
			S_VISIT: begin
				if (!stall) begin
					if (emit) begin
						pend_load = 1'b1;
						if (pend_valid_q) begin
							out_load = 1'b1;
							out_d    = '{out_value: pend_q, status: ST_VALUE, last: 1'b0};
						end
					end
					case (t_ph)
						PH_LEFT, PH_RIGHT: begin
							phase_en = 1'b1;
							phase_nx = (t_ph == PH_LEFT) ? PH_RIGHT : PH_DONE;
							if (child_ok) begin
								ram_req.rd_en   = 1'b1;
								ram_req.rd_addr = t_child[ADDR_W-1:0];
								child_d         = t_child;
							end
						end
						PH_DONE: begin
							pop_en = 1'b1;
						end
						default: ;
					endcase
				end
			end
			S_FLUSH: begin
				if (out_free) begin
					pend_drop = 1'b1;
					out_load  = 1'b1;
					out_d     = '{out_value: pend_q, status: ST_VALUE, last: 1'b1};
				end
			end
			default: ;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			wp_q         <= PTR_W'(1);
			depth_q      <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			wp_q    <= wp_d;
			if (push_en) begin
				depth_q <= depth_q + DEPTH_W'(1);
			end else if (pop_en) begin
				depth_q <= depth_q - DEPTH_W'(1);
			end
			if (pend_load) begin
				pend_valid_q <= 1'b1;
			end else if (pend_drop) begin
				pend_valid_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers and the walk stack.
	always_ff @(posedge clk) begin
		order_q <= order_d;
		child_q <= child_d;
		if (out_load) begin
			out_q <= out_d;
		end
		if (pend_load) begin
			pend_q <= t_val;
		end
		if (phase_en) begin
			stk_ph_q[top_ptr] <= phase_nx;
		end
		if (push_en) begin
			stk_idx_q[TOP_W'(depth_q)] <= child_q[ADDR_W-1:0];
			stk_ph_q[TOP_W'(depth_q)]  <= PH_LEFT;
			stk_val_q[TOP_W'(depth_q)] <= rd_data;
		end
	end

	// Checks on the walk control.
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (depth_q == '0) && !pend_valid_q)
		else $error("stack or pending word left over while idle");

	a_wp_range: assert property (@(posedge clk) disable iff (!arst_n)
		(wp_q != '0) && (wp_q <= PTR_W'(TREE_SLOTS)))
		else $error("write pointer out of range");

	a_flush_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FLUSH) |-> pend_valid_q)
		else $error("final word missing at end of walk");

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DEPTH_W'(STACK_LEVELS))
		else $error("walk stack overflow");

	a_visit_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_VISIT) |-> (depth_q != '0))
		else $error("visit with empty stack");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the array binary tree traversal block: appends, clears and
// walks go in, every output word is predicted from a model of the tree and checked in order.
// Depends on abtt_pkg and array_binary_tree_traversal.

module testbench;
	import abtt_pkg::*;

	localparam int OP_COUNT     = 430;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 64;
	localparam int PRINT_CAP    = 20;

	// Receiver behaviour while results are being taken.
	typedef enum logic [1:0] {
		RX_ALWAYS,
		RX_PATTERN,
		RX_RANDOM
	} rx_mode_t;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_ready;
	in_word_t  in_data   = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_word_t out_data;

	// Model copy of the node store and its write pointer.
	logic [VALUE_W-1:0] tree_nodes [TREE_SLOTS] = '{default: '0};
	int unsigned        next_slot = 1;

	in_word_t  op_queue [$];
	out_word_t due_words [$];
	out_word_t head_word;

	int unsigned ops_queued  = 0;
	int unsigned ops_taken   = 0;
	int unsigned words_seen  = 0;
	int unsigned walk_values = 0;
	int unsigned full_hits   = 0;
	int unsigned error_count = 0;
	int unsigned cycle_count = 0;
	int unsigned op_hits [8] = '{default: 0};

	int unsigned burst_left = 1;
	int unsigned gap_left   = 0;
	rx_mode_t    rx_mode    = RX_ALWAYS;
	logic [7:0]  rx_mask    = 8'hFF;
	int unsigned mode_left  = 0;

	array_binary_tree_traversal dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// A child is walked only when its index lies inside the store and holds a nonzero value.
	function automatic bit node_present(int unsigned idx);
		return (idx < TREE_SLOTS) && (tree_nodes[idx] != '0);
	endfunction

	// Work out the words that one accepted input word should produce, updating the model.
	function automatic void apply_tree_op(in_word_t w);
		int unsigned stack_idx [STACK_LEVELS];
		phase_t      stack_phase [STACK_LEVELS];
		int unsigned depth;
		int unsigned node;
		out_word_t   walk_words [$];
		out_word_t   word;
		word = '0;
		op_hits[w.operation]++;
		case (w.operation)
		OP_APPEND: begin
			if (next_slot >= TREE_SLOTS) begin
				word.status = ST_FULL;
				full_hits++;
			end else begin
				tree_nodes[next_slot] = w.node_value;
				next_slot++;
				word.status = ST_APPENDED;
			end
			word.last = 1'b1;
			due_words.push_back(word);
		end
		OP_CLEAR: begin
			// Only the pointer goes back; the stored values stay for later walks.
			next_slot   = 1;
			word.status = ST_CLEARED;
			word.last   = 1'b1;
			due_words.push_back(word);
		end
		OP_PRE, OP_IN, OP_POST: begin
			// Depth-first walk from the root, which is emitted even when it holds zero.
			stack_idx[0]   = 1;
			stack_phase[0] = PH_LEFT;
			depth          = 1;
			word.status    = ST_VALUE;
			while (depth > 0) begin
				node           = stack_idx[depth-1];
				word.out_value = tree_nodes[node];
				case (stack_phase[depth-1])
				PH_LEFT: begin
					if (w.operation == OP_PRE)
						walk_words.push_back(word);
					stack_phase[depth-1] = PH_RIGHT;
					if (node_present(2 * node) && depth < STACK_LEVELS) begin
						stack_idx[depth]   = 2 * node;
						stack_phase[depth] = PH_LEFT;
						depth++;
					end
				end
				PH_RIGHT: begin
					if (w.operation == OP_IN)
						walk_words.push_back(word);
					stack_phase[depth-1] = PH_DONE;
					if (node_present(2 * node + 1) && depth < STACK_LEVELS) begin
						stack_idx[depth]   = 2 * node + 1;
						stack_phase[depth] = PH_LEFT;
						depth++;
					end
				end
				default: begin
					if (w.operation == OP_POST)
						walk_words.push_back(word);
					depth--;
				end
				endcase
			end
			word      = walk_words.pop_back();
			word.last = 1'b1;
			walk_words.push_back(word);
			walk_values += walk_words.size();
			foreach (walk_words[i])
				due_words.push_back(walk_words[i]);
		end
		default: begin
			// Unused codes change nothing and give no words.
		end
		endcase
	endfunction

	function automatic void queue_op(logic [2:0] op, logic [VALUE_W-1:0] value);
		in_word_t w;
		w.operation  = op;
		w.node_value = value;
		op_queue.push_back(w);
		if (op <= OP_POST)
			ops_queued++;
	endfunction

	// Hold the sender back until every expected word has been taken.
	task automatic wait_idle();
		while (op_queue.size() != 0 || in_valid || due_words.size() != 0)
			@(posedge clk);
	endtask

	// Sender: bursts of random length, a few of them long, separated by random gaps.
	always @(posedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_ready) begin
				if (gap_left > 0 || op_queue.size() == 0) begin
					if (gap_left > 0)
						gap_left--;
					in_valid <= 1'b0;
				end else begin
					in_valid <= 1'b1;
					in_data  <= op_queue.pop_front();
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 12);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
					end
				end
			end
		end
	end

	// Receiver: switches between always ready, a rotating stall mask and coin tosses.
	always @(posedge clk) begin
		if (arst_n) begin
			if (mode_left == 0) begin
				rx_mode   = rx_mode_t'($urandom_range(0, 2));
				rx_mask   = 8'($urandom_range(1, 255));
				mode_left = $urandom_range(16, 200);
			end else begin
				mode_left--;
			end
			rx_mask = {rx_mask[6:0], rx_mask[7]};
			case (rx_mode)
			RX_ALWAYS:  out_ready <= 1'b1;
			RX_PATTERN: out_ready <= rx_mask[0];
			default:    out_ready <= 1'($urandom_range(0, 1));
			endcase
		end
	end

	// Monitor: predict on every accepted input word, then check every accepted output word.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				apply_tree_op(in_data);
				ops_taken++;
			end
			if (out_valid && out_ready) begin
				words_seen++;
				if (due_words.size() == 0) begin
					error_count++;
					if (error_count <= PRINT_CAP)
						$display("%0t: unexpected word value=%0d status=%0d last=%0b",
							$time, out_data.out_value, out_data.status, out_data.last);
				end else begin
					head_word = due_words.pop_front();
					if (out_data.out_value !== head_word.out_value ||
						out_data.status !== head_word.status ||
						out_data.last !== head_word.last) begin
						error_count++;
						if (error_count <= PRINT_CAP)
							$display("%0t: mismatch expected value=%0d status=%0d last=%0b, %s%0d status=%0d last=%0b",
								$time, head_word.out_value, head_word.status, head_word.last,
								"got value=", out_data.out_value, out_data.status, out_data.last);
					end
				end
			end
		end
	end

	// Watchdog on the whole run.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL");
		$finish;
	end

	// Stimulus: a directed opening, then random sequences built around real trees.
	initial begin
		int unsigned      append_n;
		logic [VALUE_W-1:0] pick;
		bit               mid_pause_done;
		mid_pause_done = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Walks of the empty tree still give the root with its zero value.
		queue_op(OP_PRE, '0);
		queue_op(OP_IN, '0);
		queue_op(OP_POST, '0);
		// Codes beyond the last operation are ignored.
		for (int code = OP_POST + 1; code < 8; code++)
			queue_op(3'(code), 32'hFFFF_FFFF);
		// Extreme values, with zeros acting as absent children.
		queue_op(OP_APPEND, 32'h7FFF_FFFF);
		queue_op(OP_APPEND, 32'h8000_0000);
		queue_op(OP_APPEND, 32'hFFFF_FFFF);
		queue_op(OP_APPEND, 32'h0000_0000);
		queue_op(OP_APPEND, 32'h0000_0001);
		queue_op(OP_APPEND, 32'h0000_0000);
		queue_op(OP_APPEND, 32'h0000_0005);
		queue_op(OP_PRE, '0);
		queue_op(OP_IN, '0);
		queue_op(OP_POST, '0);
		// After a clear the old values are still walked.
		queue_op(OP_CLEAR, '0);
		queue_op(OP_PRE, '0);
		queue_op(OP_IN, '0);
		queue_op(OP_POST, '0);
		queue_op(OP_APPEND, 32'h0000_002A);
		queue_op(OP_POST, '0);
		wait_idle();

		// Run past the end of the store so that the full report appears early.
		queue_op(OP_CLEAR, '0);
		repeat (TREE_SLOTS + 2)
			queue_op(OP_APPEND, $urandom() | 32'h1);
		queue_op(OP_IN, '0);

		while (ops_queued < OP_COUNT) begin
			if (!mid_pause_done && ops_queued >= OP_COUNT / 2) begin
				wait_idle();
				mid_pause_done = 1'b1;
			end
			if ($urandom_range(0, 99) < 75) begin
				// Well-formed sequence: optional clear, appends, then one or more walks.
				if ($urandom_range(0, 1) == 1)
					queue_op(OP_CLEAR, $urandom());
				append_n = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 34)
					: $urandom_range(0, 8);
				for (int k = 0; k < append_n; k++) begin
					case ($urandom_range(0, 9))
					0:       pick = '0;
					1:       pick = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
					default: pick = $urandom();
					endcase
					queue_op(OP_APPEND, pick);
				end
				repeat ($urandom_range(1, 3))
					queue_op(3'($urandom_range(OP_PRE, OP_POST)), $urandom());
			end else begin
				// Noise: any code with any value.
				queue_op(3'($urandom_range(0, 7)), $urandom());
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (due_words.size() != 0) begin
			error_count++;
			$display("%0t: %0d expected words never arrived", $time, due_words.size());
		end
		$display("Covered %0d words in: %0d appends (%0d on a full store), %0d clears, %0d walks, %0d ignored.",
			ops_taken, op_hits[OP_APPEND], full_hits, op_hits[OP_CLEAR],
			op_hits[OP_PRE] + op_hits[OP_IN] + op_hits[OP_POST],
			ops_taken - op_hits[OP_APPEND] - op_hits[OP_CLEAR] - op_hits[OP_PRE]
				- op_hits[OP_IN] - op_hits[OP_POST]);
		$display("Checked %0d words out, %0d of them node values from walks; %0d errors.",
			words_seen, walk_values, error_count);
		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/abtt_pkg.sv
hw/rtl/abtt_node_ram.sv
hw/rtl/array_binary_tree_traversal.sv
tb/testbench.sv
